>>> rtl/bfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MEM_CELLS    = 1024;
    localparam int MAX_REQUESTS = 1024;
    localparam int AW           = $clog2(MEM_CELLS + 2);
    localparam int RW           = $clog2(MAX_REQUESTS + 2);
    localparam int SW           = 11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic scan_start;   // clear run trackers, address 1
        logic scan_step;    // examine one cell
        logic mark_start;   // load mark address and count
        logic mark_step;    // write one cell
        logic mark_value;   // value written while marking
        logic grant_rd;     // read grant table at request index
        logic grant_wr;     // record grant
    } bfa_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic mark_done;
        logic found;
        logic clear_done;   // post-reset clearing pass finished
    } bfa_stat_t;

endpackage
`default_nettype wire

>>> rtl/best_fit_allocator_coalescing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_allocator_coalescing
// Best-fit cell allocator over a free-cell map with implicit coalescing.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one request per transfer: action, alloc_size,
//    request_number. Every transfer consumes a request number until the table is full.
//  - m_axis returns one transfer per allocate: status and start address.
//    A free returns nothing.
//  - mem_size_we/mem_size write the window size; write only while idle.
// Sequence (L = mem_size clamped to 1024):
//  - An allocate scans cells 1 to L (one cell per cycle behind a registered
//    map read), then passes a decision state, marks alloc_size cells and
//    passes an output state that loads the result register. With no fit
//    the marking is skipped.
//  - Failures by full table or size zero go straight to the output state
//    without a scan.
//  - A free of a live grant reads and checks its grant, then releases its
//    cells; a dead grant is read and checked only; an out-of-table number is ignored.
//  - One item is in work at a time. A result waits in the output register
//    while the next item runs; a stalled receiver holds the next result in
//    its output state, which holds tready low.
// Reset: a clearing pass frees all cells and drops all grants with tready
//  low; numbering restarts at 1, mem_size returns to 1024.
// ----------------------------------------------------------------------------
module best_fit_allocator_coalescing
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // action[0], alloc_size[11:1], request_number[22:12]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status[1:0], address[12:2]
    input  wire         mem_size_we,
    input  wire  [10:0] mem_size
);
    import bfa_pkg::*;

    bfa_cmd_t    cmd;
    bfa_stat_t   stat;
    logic [10:0] want, best_start, lim;
    logic [RW-1:0] grant_idx;
    logic        grant_set, grant_clr, grant_ok;
    logic [10:0] mem_size_reg;

    // hold window size; clamp to the physical cell count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mem_size_reg <= 11'd1024;
        else if (mem_size_we)
            mem_size_reg <= mem_size;
    end
    assign lim = ({5'd0, mem_size_reg} > 16'(MEM_CELLS)) ? 11'(MEM_CELLS) : mem_size_reg;

    bfa_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata[22:0]),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cmd(cmd), .stat(stat), .want(want), .grant_idx(grant_idx),
        .grant_set(grant_set), .grant_clr(grant_clr), .grant_ok(grant_ok),
        .best_start(best_start)
    );

    bfa_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .lim(lim), .want(want),
        .grant_idx(grant_idx), .grant_set(grant_set), .grant_clr(grant_clr),
        .grant_ok(grant_ok), .best_start(best_start)
    );

endmodule
`default_nettype wire

>>> rtl/bfa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_datapath
// Free-cell map, grant tables, best-fit scan and mark sweep.
// ----------------------------------------------------------------------------
module bfa_datapath
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire bfa_pkg::bfa_cmd_t   cmd,
    output bfa_pkg::bfa_stat_t       stat,
    input  wire [10:0]               lim,
    input  wire [10:0]               want,
    input  wire [bfa_pkg::RW-1:0]    grant_idx,
    input  wire                      grant_set,
    input  wire                      grant_clr,
    output logic                     grant_ok,
    output logic [10:0]              best_start
);
    import bfa_pkg::*;

    localparam int GW = $clog2(MAX_REQUESTS);
    localparam int MW = $clog2(MEM_CELLS);
    localparam int CW = (GW > MW) ? GW : MW;

    // 1 = used; the clearing pass after reset zeroes both bit maps
    logic             used_mem   [MEM_CELLS];
    logic             gvalid_mem [MAX_REQUESTS];
    logic [10:0]      gstart_mem [MAX_REQUESTS];
    logic [10:0]      glen_mem   [MAX_REQUESTS];

    logic [AW-1:0]    addr_reg, chk_addr_reg;
    logic             chk_valid_reg, used_q_reg;
    logic [10:0]      run_start_reg, run_len_reg, best_len_reg, best_start_reg;
    logic [11:0]      mark_cnt_reg;
    logic [10:0]      rd_start_reg, rd_len_reg;
    logic             rd_valid_reg;
    logic             scan_done_reg;
    logic [CW:0]      clr_cnt_reg;

    logic [GW-1:0] gi;
    logic          cell_free, in_range, run_fits, clearing, mark_we;
    logic [MW-1:0] cidx;
    logic          map_we, map_data;
    logic [MW-1:0] map_idx;
    logic          gv_we, gv_data;
    logic [GW-1:0] gv_idx;

    assign gi        = grant_idx[GW-1:0];
    assign clearing  = !clr_cnt_reg[CW];
    // scan checks each cell in the cycle after its map read: chk_addr_reg names used_q_reg
    assign in_range  = ({{(16-AW){1'b0}}, chk_addr_reg} <= {5'd0, lim});
    assign cidx      = MW'(addr_reg - AW'(1));
    assign cell_free = in_range && !used_q_reg;
    assign run_fits  = (run_len_reg >= want) && (run_len_reg != 11'd0) &&
                       (best_len_reg == 11'd0 || run_len_reg < best_len_reg);
    assign mark_we   = cmd.mark_step && (mark_cnt_reg != 12'd0) &&
                       (addr_reg >= AW'(1)) && (addr_reg <= AW'(MEM_CELLS));

    assign map_we   = clearing || mark_we;
    assign map_idx  = clearing ? clr_cnt_reg[MW-1:0] : cidx;
    assign map_data = clearing ? 1'b0 : !cmd.mark_value;
    assign gv_we    = clearing || grant_set || grant_clr;
    assign gv_idx   = clearing ? clr_cnt_reg[GW-1:0] : gi;
    assign gv_data  = !clearing && grant_set;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            scan_done_reg  <= 1'b0;
            mark_cnt_reg   <= '0;
            addr_reg       <= '0;
            chk_addr_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
        end
        else
        begin
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + (CW+1)'(1);
            if (cmd.scan_start)
            begin
                addr_reg       <= AW'(1);
                chk_valid_reg  <= 1'b0;
                scan_done_reg  <= 1'b0;
                run_len_reg    <= '0;
                best_len_reg   <= '0;
                best_start_reg <= '0;
            end
            else if (cmd.scan_step && !scan_done_reg)
            begin
                if (chk_valid_reg)
                begin
                    if (cell_free)
                    begin
                        if (run_len_reg == 11'd0)
                            run_start_reg <= chk_addr_reg[10:0];
                        run_len_reg <= run_len_reg + 11'd1;
                    end
                    else
                    begin
                        if (run_fits)
                        begin
                            best_len_reg   <= run_len_reg;
                            best_start_reg <= run_start_reg;
                        end
                        run_len_reg <= '0;
                        if (!in_range)
                            scan_done_reg <= 1'b1;
                    end
                end
                chk_addr_reg  <= addr_reg;
                chk_valid_reg <= 1'b1;
                addr_reg      <= addr_reg + AW'(1);
            end
            else if (cmd.mark_start)
            begin
                addr_reg     <= AW'(cmd.mark_value ? rd_start_reg : best_start_reg);
                mark_cnt_reg <= {1'b0, cmd.mark_value ? rd_len_reg : want};
            end
            else if (cmd.mark_step && mark_cnt_reg != 12'd0)
            begin
                addr_reg     <= addr_reg + AW'(1);
                mark_cnt_reg <= mark_cnt_reg - 12'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            used_mem[map_idx] <= map_data;
        used_q_reg <= used_mem[cidx];
        if (gv_we)
            gvalid_mem[gv_idx] <= gv_data;
        if (cmd.grant_wr)
        begin
            gstart_mem[gi] <= best_start_reg;
            glen_mem[gi]   <= want;
        end
        if (cmd.grant_rd)
        begin
            rd_start_reg <= gstart_mem[gi];
            rd_len_reg   <= glen_mem[gi];
            rd_valid_reg <= gvalid_mem[gi];
        end
    end

    assign grant_ok        = rd_valid_reg;
    assign best_start      = best_start_reg;
    assign stat.scan_done  = scan_done_reg;
    assign stat.mark_done  = (mark_cnt_reg == 12'd0);
    assign stat.found      = (best_len_reg != 11'd0);
    assign stat.clear_done = !clearing;

endmodule
`default_nettype wire

>>> rtl/bfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: takes an item, runs scan/mark or the grant lookup, emits allocate results.
// ----------------------------------------------------------------------------
module bfa_ctrl
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [22:0]             s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [15:0]            m_axis_tdata,
    output bfa_pkg::bfa_cmd_t      cmd,
    input  wire bfa_pkg::bfa_stat_t stat,
    output logic [10:0]            want,
    output logic [bfa_pkg::RW-1:0] grant_idx,
    output logic                   grant_set,
    output logic                   grant_clr,
    input  wire                    grant_ok,
    input  wire [10:0]             best_start
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ALLOC, S_MARK, S_FREAD, S_FCHK,
                              S_OUT} state_t;

    state_t      state_reg;
    logic [RW-1:0] next_req_reg, idx_reg;
    logic [10:0] want_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg, out_status_reg;
    logic [10:0] addr_reg, out_addr_reg;
    logic        mval_reg;

    logic        act;
    logic [10:0] in_size, in_rn;
    logic        full, take, rn_ok, out_load;

    assign act     = s_axis_tdata[0];
    assign in_size = s_axis_tdata[11:1];
    assign in_rn   = s_axis_tdata[22:12];
    assign full    = (next_req_reg > RW'(MAX_REQUESTS));
    assign take    = s_axis_tvalid && s_axis_tready;
    assign rn_ok   = (in_rn >= 11'd1) && ({5'd0, in_rn} <= 16'(MAX_REQUESTS));
    // load the output register once the previous result has left
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == S_IDLE) && stat.clear_done;

    always_comb
    begin
        cmd = '0;
        cmd.mark_value = mval_reg;
        grant_set = 1'b0;
        grant_clr = 1'b0;
        grant_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                grant_idx = (act == ACT_FREE) ? RW'(in_rn - 11'd1) : next_req_reg - RW'(1);
                cmd.scan_start = 1'b1;
                cmd.grant_rd   = take && act == ACT_FREE;
                grant_clr      = take && act == ACT_ALLOC && !full;
            end
            S_SCAN:  cmd.scan_step = 1'b1;
            S_ALLOC:
            begin
                cmd.mark_start = stat.found;
                cmd.grant_wr   = stat.found;
                grant_set      = stat.found;
            end
            S_FCHK:
            begin
                cmd.mark_start = grant_ok;
                grant_clr      = grant_ok;
            end
            S_MARK:  cmd.mark_step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_req_reg   <= RW'(1);
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_addr_reg   <= '0;
            idx_reg        <= '0;
            mval_reg       <= 1'b0;
            want_reg       <= '0;
            status_reg     <= '0;
            addr_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_reg;
                out_addr_reg   <= addr_reg;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        want_reg <= in_size;
                        if (act == ACT_FREE && rn_ok)
                            idx_reg <= RW'(in_rn - 11'd1);
                        else
                            idx_reg <= next_req_reg - RW'(1);
                        if (!full)
                            next_req_reg <= next_req_reg + RW'(1);
                        if (act == ACT_FREE)
                        begin
                            mval_reg <= 1'b1;
                            if (rn_ok)
                                state_reg <= S_FREAD;
                        end
                        else
                        begin
                            mval_reg <= 1'b0;
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                                addr_reg   <= '0;
                                state_reg  <= S_OUT;
                            end
                            else if (in_size == 11'd0)
                            begin
                                status_reg <= ST_NOFIT;
                                addr_reg   <= '0;
                                state_reg  <= S_OUT;
                            end
                            else
                                state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:  if (stat.scan_done) state_reg <= S_ALLOC;
                S_ALLOC:
                begin
                    status_reg <= stat.found ? ST_OK : ST_NOFIT;
                    addr_reg   <= stat.found ? best_start : 11'd0;
                    state_reg  <= stat.found ? S_MARK : S_OUT;
                end
                S_FREAD: state_reg <= S_FCHK;
                S_FCHK:  state_reg <= grant_ok ? S_MARK : S_IDLE;
                S_MARK:  if (stat.mark_done) state_reg <= mval_reg ? S_IDLE : S_OUT;
                S_OUT:   if (out_load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign want          = want_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_addr_reg, out_status_reg};

endmodule
`default_nettype wire

>>> rtl/bfa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_port_checks
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    import bfa_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[12:2] == 11'd0)
        else $error("failed allocate has nonzero address");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_OK |-> m_axis_tdata[12:2] != 11'd0)
        else $error("granted address zero");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready}))
        else $error("handshake signal unknown");

endmodule

bind best_fit_allocator_coalescing bfa_port_checks u_chk
(
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> dv/bfa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfa_checker
// Watches the request and result streams, keeps a private allocator model and
// compares every result transfer against the oldest predicted one.
// ----------------------------------------------------------------------------
module bfa_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         req_valid,
    input  wire         req_ready,
    input  wire  [23:0] req_data,
    input  wire         res_valid,
    input  wire         res_ready,
    input  wire  [15:0] res_data,
    input  wire         size_we,
    input  wire  [10:0] size_val,
    output int          fail_count,
    output int          pending,
    output int          n_results
);
    import bfa_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] address;
    } grant_res_t;

    logic        cell_open [1:MEM_CELLS];
    logic [10:0] blk_start [1:MAX_REQUESTS];
    logic [10:0] blk_len   [1:MAX_REQUESTS];
    logic        blk_live  [1:MAX_REQUESTS];
    int          req_num;
    int          window;
    grant_res_t  grant_q [$];

    initial
    begin
        for (int a = 1; a <= MEM_CELLS; a++) cell_open[a] = 1'b1;
        for (int r = 1; r <= MAX_REQUESTS; r++) blk_live[r] = 1'b0;
        req_num    = 1;
        window     = 1024;
        fail_count = 0;
        pending    = 0;
        n_results  = 0;
    end

    // Best fit: smallest run >= want, lowest address on ties; 0 when none.
    function automatic int find_run(int want);
        int lim;
        int best_s;
        int best_l;
        int run_s;
        int run_l;
        bit open;
        lim    = (window > MEM_CELLS) ? MEM_CELLS : window;
        best_s = 0;
        best_l = 0;
        run_s  = 0;
        run_l  = 0;
        for (int a = 1; a <= lim + 1; a++)
        begin
            open = (a <= lim) && cell_open[a];
            if (open)
            begin
                if (run_l == 0) run_s = a;
                run_l++;
            end
            else
            begin
                if (run_l >= want && (best_l == 0 || run_l < best_l))
                begin
                    best_l = run_l;
                    best_s = run_s;
                end
                run_l = 0;
            end
        end
        return best_s;
    endfunction

    task automatic set_cells(int s, int n, logic v);
        for (int a = s; a < s + n && a <= MEM_CELLS; a++) cell_open[a] = v;
    endtask

    task automatic apply_request(logic [23:0] d);
        logic       act;
        int         sz;
        int         rn;
        grant_res_t g;
        act = d[0];
        sz  = d[11:1];
        rn  = d[22:12];
        if (act == ACT_FREE)
        begin
            if (req_num <= MAX_REQUESTS) req_num++;
            if (rn >= 1 && rn <= MAX_REQUESTS && blk_live[rn])
            begin
                set_cells(blk_start[rn], blk_len[rn], 1'b1);
                blk_live[rn] = 1'b0;
            end
        end
        else
        begin
            g.address = '0;
            if (req_num > MAX_REQUESTS)
                g.status = ST_FULL;
            else
            begin
                blk_live[req_num] = 1'b0;
                g.address = (sz == 0) ? 11'd0 : 11'(find_run(sz));
                if (g.address == 0)
                    g.status = ST_NOFIT;
                else
                begin
                    g.status = ST_OK;
                    set_cells(g.address, sz, 1'b0);
                    blk_start[req_num] = g.address;
                    blk_len[req_num]   = 11'(sz);
                    blk_live[req_num]  = 1'b1;
                end
                req_num++;
            end
            grant_q.push_back(g);
        end
    endtask

    always @(posedge clk)
    begin
        grant_res_t exp_r;
        grant_res_t got;
        if (rst_n)
        begin
            if (size_we) window = size_val;
            if (res_valid && res_ready)
            begin
                got = '{status: res_data[1:0], address: res_data[12:2]};
                n_results++;
                if (grant_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: expected none, got status=%0d addr=%0d",
                                 got.status, got.address);
                end
                else
                begin
                    exp_r = grant_q.pop_front();
                    if (got.status !== exp_r.status || got.address !== exp_r.address)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected status=%0d addr=%0d, got %0d/%0d",
                                     exp_r.status, exp_r.address, got.status, got.address);
                    end
                end
            end
            if (req_valid && req_ready) apply_request(req_data);
            pending = grant_q.size();
        end
    end

endmodule

>>> dv/best_fit_allocator_coalescing_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_allocator_coalescing_tb
// Drives allocate/free traffic with random idling on both streams, changes
// the window size between phases and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module best_fit_allocator_coalescing_tb;
    import bfa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // action[0], alloc_size[11:1], request_number[22:12]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status[1:0], address[12:2]
    logic        mem_size_we;
    logic [10:0] mem_size;

    int  fail_count;
    int  pending;
    int  n_results;
    int  cycle_cnt;
    int  sent;
    int  n_alloc;
    int  n_free;
    bit  quiet;       // no idling in the closing stretch

    localparam int CYCLE_LIMIT = 4_000_000;

    best_fit_allocator_coalescing DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mem_size_we   (mem_size_we),
        .mem_size      (mem_size)
    );

    bfa_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_data   (s_axis_tdata),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_data   (m_axis_tdata),
        .size_we    (mem_size_we),
        .size_val   (mem_size),
        .fail_count (fail_count),
        .pending    (pending),
        .n_results  (n_results)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: hold tready low in random bursts, except in the quiet stretch.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 13);
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // Send one request; hold it until the transfer happens.
    task automatic send_req(logic act, int sz, int rn);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tdata  = {1'b0, 11'(rn), 11'(sz), act};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        sent++;
        if (act == ACT_ALLOC) n_alloc++;
        else n_free++;
    endtask

    // Wait until every predicted result has arrived, then let the block settle.
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    task automatic write_size(int v);
        drain();
        mem_size    = 11'(v);
        mem_size_we = 1'b1;
        @(negedge clk);
        mem_size_we = 1'b0;
    endtask

    // Mostly small sizes; occasionally zero or a large one.
    function automatic int pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 3) return 0;
        if (p < 80) return $urandom_range(1, 24);
        if (p < 95) return $urandom_range(25, 200);
        return $urandom_range(201, 2047);
    endfunction

    task automatic random_phase(int n);
        int rn;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 60)
                send_req(ACT_ALLOC, pick_size(), $urandom_range(0, 2047));
            else
            begin
                // Aim most frees at recent requests; the rest are noise.
                if ($urandom_range(0, 9) < 8)
                    rn = (sent > 0) ? $urandom_range((sent > 40) ? sent - 40 : 1, sent) : 1;
                else
                    rn = $urandom_range(0, 2047);
                send_req(ACT_FREE, $urandom_range(0, 2047), rn);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mem_size_we   = 1'b0;
        mem_size      = 11'd1024;
        quiet         = 1'b0;
        sent          = 0;
        n_alloc       = 0;
        n_free        = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, coalescing, ties, bad frees.
        send_req(ACT_ALLOC, 0, 0);          // size zero
        send_req(ACT_ALLOC, 2047, 2047);    // too big
        send_req(ACT_ALLOC, 1024, 0);       // whole memory
        send_req(ACT_FREE, 0, 3);           // release it
        send_req(ACT_ALLOC, 10, 0);         // 5
        send_req(ACT_ALLOC, 5, 0);          // 6
        send_req(ACT_ALLOC, 10, 0);         // 7
        send_req(ACT_ALLOC, 5, 0);          // 8
        send_req(ACT_FREE, 0, 5);           // hole of 10
        send_req(ACT_FREE, 0, 7);           // second hole of 10: tie
        send_req(ACT_ALLOC, 8, 0);          // lowest hole wins
        send_req(ACT_FREE, 0, 6);           // merge neighbors
        send_req(ACT_FREE, 0, 6);           // double free ignored
        send_req(ACT_FREE, 0, 1);           // failed request
        send_req(ACT_FREE, 0, 4);           // was a free
        send_req(ACT_FREE, 0, 0);           // number zero
        send_req(ACT_FREE, 0, 2047);        // beyond table
        send_req(ACT_ALLOC, 1, 0);
        send_req(ACT_FREE, 0, 11);

        // Sender pause until everything expected has come back.
        drain();

        write_size(1);
        send_req(ACT_ALLOC, 1, 0);
        send_req(ACT_ALLOC, 1, 0);
        write_size(0);
        send_req(ACT_ALLOC, 1, 0);
        write_size(2047);
        send_req(ACT_ALLOC, 3, 0);
        write_size(64);
        random_phase(120);
        write_size($urandom_range(2, 1023));
        random_phase(120);
        write_size(1024);
        random_phase(150);
        write_size(200);
        quiet = 1'b1;
        random_phase(130);
        send_req(ACT_ALLOC, 0, 0);
        send_req(ACT_ALLOC, 5, 0);
        send_req(ACT_FREE, 0, $urandom_range(1, 1024));
        send_req(ACT_ALLOC, 2, 0);

        drain();
        $display("covered %0d requests (%0d allocates, %0d frees), %0d results checked",
                 sent, n_alloc, n_free, n_results);
        $display("window sizes 0, 1, 64, 200, 1024 and above range; ties, merges, bad frees");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
